FILE: design/frs_pkg.sv
package frs_pkg;

  localparam int RATE_WINDOWS = 3;
  localparam int NUM_WIN = 3;
  localparam int NUM_KIND = 3;
  localparam int HDR_BYTES = 14;
  localparam int SCALE = 1000;
  localparam int DIV_W = 40;
  localparam int DIV_BITS = 8;
  localparam int DIV_STEPS = DIV_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int WGT_W = 7;
  localparam int REM_W = WGT_W - 1;
  localparam logic [15:0] TICKS_RESET = 16'd1000;

  typedef enum logic [1:0] {
    FUNC_SEND  = 2'd0,
    FUNC_RECV  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } frs_func_t;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_LOSS  = 2'd2
  } frs_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DELTA,
    ST_MUL,
    ST_DIV,
    ST_COMMIT,
    ST_DONE
  } frs_state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_ticks;
    logic [10:0] frame_size;
    logic        send_ok;
  } frs_in_t;

  typedef struct packed {
    logic [31:0]        frame_rate_1s;
    logic [31:0]        frame_rate_10s;
    logic [31:0]        frame_rate_60s;
    logic [31:0]        byte_rate_1s;
    logic [31:0]        byte_rate_10s;
    logic [31:0]        byte_rate_60s;
    logic signed [31:0] loss_rate_1s;
    logic signed [31:0] loss_rate_10s;
    logic signed [31:0] loss_rate_60s;
    logic [31:0]        sent_total;
    logic [31:0]        error_total;
    logic [31:0]        received_total;
  } frs_out_t;

  function automatic logic [WGT_W-1:0] win_weight(input logic [1:0] k);
    case (k)
      2'd0:    win_weight = WGT_W'(1);
      2'd1:    win_weight = WGT_W'(10);
      2'd2:    win_weight = WGT_W'(60);
      default: win_weight = WGT_W'(1);
    endcase
  endfunction

endpackage

FILE: design/frame_rate_statistics.sv
// Frame link statistics. Each accepted item (send, receive, clear or unused
// code) returns one snapshot of the counters and of the nine moving averages
// after the update. An item without a window update passes the check, commit
// and done states, and the input is free again once its result is loaded. A
// send that closes a window first runs the delta state, then takes every
// average through one shared multiply-add and a divider that retires 8
// quotient bits a cycle. The input is stalled while an item is in work; a
// finished result waits in the output register, so the next item is taken
// while it is still held.
module frame_rate_statistics (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  frs_pkg::frs_in_t  in_item,
  output logic            out_valid,
  input  logic            out_stall,
  output frs_pkg::frs_out_t out_item,
  input  logic            cfg_write,
  input  logic [15:0]     cfg_data
);

  frs_pkg::frs_state_t state, state_next;

  logic [15:0] ticks_per_second;
  frs_pkg::frs_in_t item;
  logic        upd;

  logic [31:0] sent_count, recv_count, err_count, byte_count;
  logic [31:0] prev_sent_count, prev_byte_count, prev_loss, window_start;
  logic [31:0] avgs [frs_pkg::NUM_KIND][frs_pkg::NUM_WIN];

  logic [31:0] fr, br, lr, loss;
  logic [1:0]  kind, win;
  logic [frs_pkg::DIV_CNT_W-1:0] step;
  logic [frs_pkg::DIV_W-1:0] div_reg, div_next;
  logic [frs_pkg::REM_W-1:0] rem, rem_next;
  logic        neg;

  logic        check_upd, last_step, last_pair, load_out;
  logic [frs_pkg::WGT_W-1:0] weight;
  logic [frs_pkg::DIV_W-1:0] avg_ext, val_ext, mul_sum, mul_mag;
  logic [31:0] val_sel, quot;

  assign check_upd = (frs_pkg::frs_func_t'(item.func) == frs_pkg::FUNC_SEND) &&
                     ((item.now_ticks - window_start) >= {16'd0, ticks_per_second});
  assign weight = frs_pkg::win_weight(win);
  assign last_step = (step == frs_pkg::DIV_CNT_W'(frs_pkg::DIV_STEPS - 1));
  assign last_pair = (frs_pkg::frs_kind_t'(kind) == frs_pkg::KIND_LOSS) &&
                     (win == 2'(frs_pkg::RATE_WINDOWS - 1));

  // shared multiply-add: avg * (n - 1) + new
  always_comb begin
    case (frs_pkg::frs_kind_t'(kind))
      frs_pkg::KIND_FRAME: val_sel = fr;
      frs_pkg::KIND_BYTE:  val_sel = br;
      frs_pkg::KIND_LOSS:  val_sel = lr;
      default:             val_sel = fr;
    endcase
    if (frs_pkg::frs_kind_t'(kind) == frs_pkg::KIND_LOSS) begin
      avg_ext = {{(frs_pkg::DIV_W-32){avgs[kind][win][31]}}, avgs[kind][win]};
      val_ext = {{(frs_pkg::DIV_W-32){val_sel[31]}}, val_sel};
    end else begin
      avg_ext = {{(frs_pkg::DIV_W-32){1'b0}}, avgs[kind][win]};
      val_ext = {{(frs_pkg::DIV_W-32){1'b0}}, val_sel};
    end
    mul_sum = avg_ext * frs_pkg::DIV_W'(weight - frs_pkg::WGT_W'(1)) + val_ext;
    mul_mag = mul_sum[frs_pkg::DIV_W-1] ? (~mul_sum + frs_pkg::DIV_W'(1)) : mul_sum;
  end

  // divider step, several restoring steps on a narrow remainder
  always_comb begin
    logic [frs_pkg::WGT_W-1:0] r;
    logic [frs_pkg::REM_W-1:0] rt;
    logic [frs_pkg::DIV_W-1:0] d;
    rt = rem;
    d = div_reg;
    for (int i = 0; i < frs_pkg::DIV_BITS; i++) begin
      r = {rt, d[frs_pkg::DIV_W-1]};
      d = {d[frs_pkg::DIV_W-2:0], 1'b0};
      if (r >= weight) begin
        r = r - weight;
        d[0] = 1'b1;
      end
      rt = r[frs_pkg::REM_W-1:0];
    end
    rem_next = rt;
    div_next = d;
    quot = neg ? (~div_next[31:0] + 32'd1) : div_next[31:0];
  end

  always_comb begin
    case (state)
      frs_pkg::ST_IDLE:   state_next = in_valid ? frs_pkg::ST_CHECK : frs_pkg::ST_IDLE;
      frs_pkg::ST_CHECK:  state_next = check_upd ? frs_pkg::ST_DELTA : frs_pkg::ST_COMMIT;
      frs_pkg::ST_DELTA:  state_next = frs_pkg::ST_MUL;
      frs_pkg::ST_MUL:    state_next = frs_pkg::ST_DIV;
      frs_pkg::ST_DIV: begin
        if (!last_step) state_next = frs_pkg::ST_DIV;
        else if (last_pair) state_next = frs_pkg::ST_COMMIT;
        else state_next = frs_pkg::ST_MUL;
      end
      frs_pkg::ST_COMMIT: state_next = frs_pkg::ST_DONE;
      frs_pkg::ST_DONE:   state_next = load_out ? frs_pkg::ST_IDLE : frs_pkg::ST_DONE;
      default:            state_next = frs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != frs_pkg::ST_IDLE);
    load_out = (state == frs_pkg::ST_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= frs_pkg::TICKS_RESET;
    end else if (cfg_write) begin
      ticks_per_second <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item.frame_rate_1s  <= avgs[frs_pkg::KIND_FRAME][0];
      out_item.frame_rate_10s <= avgs[frs_pkg::KIND_FRAME][1];
      out_item.frame_rate_60s <= avgs[frs_pkg::KIND_FRAME][2];
      out_item.byte_rate_1s   <= avgs[frs_pkg::KIND_BYTE][0];
      out_item.byte_rate_10s  <= avgs[frs_pkg::KIND_BYTE][1];
      out_item.byte_rate_60s  <= avgs[frs_pkg::KIND_BYTE][2];
      out_item.loss_rate_1s   <= avgs[frs_pkg::KIND_LOSS][0];
      out_item.loss_rate_10s  <= avgs[frs_pkg::KIND_LOSS][1];
      out_item.loss_rate_60s  <= avgs[frs_pkg::KIND_LOSS][2];
      out_item.sent_total     <= sent_count;
      out_item.error_total    <= err_count;
      out_item.received_total <= recv_count;
    end
  end

  // item capture, deltas and divider datapath
  always_ff @(posedge clk) begin
    if (state == frs_pkg::ST_IDLE && in_valid) begin
      item <= in_item;
    end
    if (state == frs_pkg::ST_CHECK) begin
      upd <= check_upd;
    end
    if (state == frs_pkg::ST_DELTA) begin
      fr   <= (sent_count - prev_sent_count) * 32'(frs_pkg::SCALE);
      br   <= byte_count - prev_byte_count;
      lr   <= ((sent_count - recv_count) - prev_loss) * 32'(frs_pkg::SCALE);
      loss <= sent_count - recv_count;
      kind <= frs_pkg::KIND_FRAME;
      win  <= 2'd0;
    end
    if (state == frs_pkg::ST_MUL) begin
      neg     <= mul_sum[frs_pkg::DIV_W-1];
      div_reg <= mul_mag;
      rem     <= '0;
      step    <= '0;
    end
    if (state == frs_pkg::ST_DIV) begin
      div_reg <= div_next;
      rem     <= rem_next;
      step    <= step + frs_pkg::DIV_CNT_W'(1);
      if (last_step) begin
        if (frs_pkg::frs_kind_t'(kind) == frs_pkg::KIND_LOSS) begin
          kind <= frs_pkg::KIND_FRAME;
          win  <= win + 2'd1;
        end else begin
          kind <= kind + 2'd1;
        end
      end
    end
  end

  // statistics state
  always_ff @(posedge clk) begin
    if (rst) begin
      sent_count      <= '0;
      recv_count      <= '0;
      err_count       <= '0;
      byte_count      <= '0;
      prev_sent_count <= '0;
      prev_byte_count <= '0;
      prev_loss       <= '0;
      window_start    <= '0;
      for (int k = 0; k < frs_pkg::NUM_KIND; k++) begin
        for (int j = 0; j < frs_pkg::NUM_WIN; j++) begin
          avgs[k][j] <= '0;
        end
      end
    end else begin
      if (state == frs_pkg::ST_DIV && last_step) begin
        avgs[kind][win] <= quot;
      end
      if (state == frs_pkg::ST_COMMIT) begin
        if (upd) begin
          prev_sent_count <= sent_count;
          prev_byte_count <= byte_count;
          prev_loss       <= loss;
          window_start    <= item.now_ticks;
        end
        case (frs_pkg::frs_func_t'(item.func))
          frs_pkg::FUNC_SEND: begin
            if (item.send_ok) begin
              sent_count <= sent_count + 32'd1;
              byte_count <= byte_count + 32'(frs_pkg::HDR_BYTES) + {21'd0, item.frame_size};
            end else begin
              err_count <= err_count + 32'd1;
            end
          end
          frs_pkg::FUNC_RECV: recv_count <= recv_count + 32'd1;
          frs_pkg::FUNC_CLEAR: begin
            sent_count      <= '0;
            recv_count      <= '0;
            err_count       <= '0;
            byte_count      <= '0;
            prev_sent_count <= '0;
            prev_byte_count <= '0;
            prev_loss       <= '0;
            for (int k = 0; k < frs_pkg::NUM_KIND; k++) begin
              for (int j = 0; j < frs_pkg::NUM_WIN; j++) begin
                avgs[k][j] <= '0;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after an item");

  a_div_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == frs_pkg::ST_DIV) |-> (step < frs_pkg::DIV_CNT_W'(frs_pkg::DIV_STEPS)))
    else $error("divider step out of range");

  a_win_range: assert property (@(posedge clk) disable iff (rst)
    (state == frs_pkg::ST_MUL || state == frs_pkg::ST_DIV) |->
      (win < 2'(frs_pkg::RATE_WINDOWS)))
    else $error("window index out of range");

  a_commit_to_done: assert property (@(posedge clk) disable iff (rst)
    (state == frs_pkg::ST_COMMIT) |=> (state == frs_pkg::ST_DONE))
    else $error("commit not followed by result");

  a_sent_count: assert property (@(posedge clk) disable iff (rst)
    (state == frs_pkg::ST_COMMIT && item.func == frs_pkg::FUNC_SEND && item.send_ok)
      |=> (sent_count == $past(sent_count) + 32'd1))
    else $error("good send not counted");
`endif

endmodule

FILE: verif/frs_snapshot_check.sv
`timescale 1ns / 100ps

module frs_snapshot_check (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  frs_pkg::frs_in_t  in_item,
  input  logic              out_valid,
  input  logic              out_stall,
  input  frs_pkg::frs_out_t out_item,
  input  logic              cfg_write,
  input  logic [15:0]       cfg_data,
  output int                errors,
  output int                pending,
  output int                windows_closed
);

  logic [15:0]        window_len;
  logic [31:0]        sent_cnt, recv_cnt, err_cnt, byte_cnt;
  logic [31:0]        sent_mark, byte_mark, loss_mark, window_mark;
  logic [31:0]        frame_avg [3];
  logic [31:0]        byte_avg [3];
  logic signed [31:0] loss_avg [3];
  frs_pkg::frs_out_t  snapshot_q [$];

  task automatic clear_stats();
    sent_cnt = '0;
    recv_cnt = '0;
    err_cnt = '0;
    byte_cnt = '0;
    sent_mark = '0;
    byte_mark = '0;
    loss_mark = '0;
    for (int k = 0; k < 3; k++) begin
      frame_avg[k] = '0;
      byte_avg[k] = '0;
      loss_avg[k] = '0;
    end
  endtask

  function automatic logic [31:0] fold_unsigned(input logic [31:0] avg,
                                                input logic [31:0] sample,
                                                input int unsigned weight);
    logic [63:0] acc;
    acc = {32'd0, avg} * 64'(weight - 1) + {32'd0, sample};
    return 32'(acc / 64'(weight));
  endfunction

  task automatic apply_event(input frs_pkg::frs_in_t ev, output frs_pkg::frs_out_t snap);
    logic [31:0]        elapsed, frame_delta, byte_delta, loss_now;
    logic signed [31:0] loss_delta;
    longint             signed_acc;
    int unsigned        weight;
    case (ev.func)
      frs_pkg::FUNC_SEND: begin
        elapsed = ev.now_ticks - window_mark;
        if (elapsed >= {16'd0, window_len}) begin
          frame_delta = (sent_cnt - sent_mark) * 32'(frs_pkg::SCALE);
          byte_delta = byte_cnt - byte_mark;
          loss_now = sent_cnt - recv_cnt;
          loss_delta = (loss_now - loss_mark) * 32'(frs_pkg::SCALE);
          for (int k = 0; k < frs_pkg::RATE_WINDOWS; k++) begin
            weight = (k == 0) ? 1 : (k == 1) ? 10 : 60;
            frame_avg[k] = fold_unsigned(frame_avg[k], frame_delta, weight);
            byte_avg[k] = fold_unsigned(byte_avg[k], byte_delta, weight);
            signed_acc = longint'(loss_avg[k]) * longint'(weight - 1) + longint'(loss_delta);
            loss_avg[k] = 32'(signed_acc / longint'(weight));
          end
          sent_mark = sent_cnt;
          byte_mark = byte_cnt;
          loss_mark = loss_now;
          window_mark = ev.now_ticks;
          windows_closed = windows_closed + 1;
        end
        if (ev.send_ok) begin
          sent_cnt = sent_cnt + 1;
          byte_cnt = byte_cnt + 32'(frs_pkg::HDR_BYTES) + 32'(ev.frame_size);
        end else begin
          err_cnt = err_cnt + 1;
        end
      end
      frs_pkg::FUNC_RECV: begin
        recv_cnt = recv_cnt + 1;
      end
      frs_pkg::FUNC_CLEAR: begin
        clear_stats();
      end
      default: ;
    endcase
    snap.frame_rate_1s = frame_avg[0];
    snap.frame_rate_10s = frame_avg[1];
    snap.frame_rate_60s = frame_avg[2];
    snap.byte_rate_1s = byte_avg[0];
    snap.byte_rate_10s = byte_avg[1];
    snap.byte_rate_60s = byte_avg[2];
    snap.loss_rate_1s = loss_avg[0];
    snap.loss_rate_10s = loss_avg[1];
    snap.loss_rate_60s = loss_avg[2];
    snap.sent_total = sent_cnt;
    snap.error_total = err_cnt;
    snap.received_total = recv_cnt;
  endtask

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors = errors + 1;
      $display("%0t: %s expected %h got %h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    frs_pkg::frs_out_t want, snap;
    if (rst) begin
      window_len = frs_pkg::TICKS_RESET;
      window_mark = '0;
      clear_stats();
      snapshot_q.delete();
      errors = 0;
      windows_closed = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (snapshot_q.size() == 0) begin
          errors = errors + 1;
          $display("%0t: snapshot arrived with none expected", $time);
        end else begin
          want = snapshot_q.pop_front();
          check_field("frame_rate_1s", want.frame_rate_1s, out_item.frame_rate_1s);
          check_field("frame_rate_10s", want.frame_rate_10s, out_item.frame_rate_10s);
          check_field("frame_rate_60s", want.frame_rate_60s, out_item.frame_rate_60s);
          check_field("byte_rate_1s", want.byte_rate_1s, out_item.byte_rate_1s);
          check_field("byte_rate_10s", want.byte_rate_10s, out_item.byte_rate_10s);
          check_field("byte_rate_60s", want.byte_rate_60s, out_item.byte_rate_60s);
          check_field("loss_rate_1s", want.loss_rate_1s, out_item.loss_rate_1s);
          check_field("loss_rate_10s", want.loss_rate_10s, out_item.loss_rate_10s);
          check_field("loss_rate_60s", want.loss_rate_60s, out_item.loss_rate_60s);
          check_field("sent_total", want.sent_total, out_item.sent_total);
          check_field("error_total", want.error_total, out_item.error_total);
          check_field("received_total", want.received_total, out_item.received_total);
        end
      end
      if (cfg_write) begin
        window_len = cfg_data;
      end
      if (in_valid && !in_stall) begin
        apply_event(in_item, snap);
        snapshot_q.push_back(snap);
      end
    end
    pending = snapshot_q.size();
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  logic              clk;
  logic              rst;
  logic              in_valid, in_stall;
  frs_pkg::frs_in_t  in_item;
  logic              out_valid, out_stall;
  frs_pkg::frs_out_t out_item;
  logic              cfg_write;
  logic [15:0]       cfg_data;
  int                errors, pending, windows_closed;

  logic [31:0] tick_now;
  logic [15:0] window_len;
  bit          idle_on;
  int          n_send, n_recv, n_clear, n_unused, n_lengths;

  frame_rate_statistics DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  frs_snapshot_check snapshot_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .errors         (errors),
    .pending        (pending),
    .windows_closed (windows_closed)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= idle_on && ($urandom_range(0, 99) < 9);
  end

  task automatic post_event(input logic [1:0] func, input logic [31:0] ticks,
                            input logic [10:0] size, input logic ok);
    frs_pkg::frs_in_t ev;
    ev.func = func;
    ev.now_ticks = ticks;
    ev.frame_size = size;
    ev.send_ok = ok;
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= ev;
    do @(posedge clk); while (in_stall);
    case (func)
      frs_pkg::FUNC_SEND:  n_send++;
      frs_pkg::FUNC_RECV:  n_recv++;
      frs_pkg::FUNC_CLEAR: n_clear++;
      default:             n_unused++;
    endcase
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_window(input logic [15:0] len);
    quiesce();
    repeat (2) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= len;
    window_len = len;
    @(negedge clk);
    cfg_write <= 1'b0;
    n_lengths++;
  endtask

  // mostly ordered tick stream, some items with random ticks and func
  task automatic random_event();
    int          pick;
    logic [31:0] ticks;
    logic [10:0] size;
    logic [1:0]  func;
    pick = $urandom_range(0, 99);
    tick_now = tick_now + $urandom_range(0, window_len / 4 + 2);
    ticks = tick_now;
    if ($urandom_range(0, 19) == 0)
      size = 11'($urandom_range(1501, 2047));
    else
      size = 11'($urandom_range(0, 1500));
    if (pick < 55) begin
      func = frs_pkg::FUNC_SEND;
    end else if (pick < 85) begin
      func = frs_pkg::FUNC_RECV;
    end else if (pick < 88) begin
      func = frs_pkg::FUNC_CLEAR;
    end else if (pick < 92) begin
      func = frs_pkg::FUNC_NONE;
    end else begin
      func = 2'($urandom_range(0, 3));
      ticks = $urandom;
    end
    post_event(func, ticks, size, $urandom_range(0, 9) != 0);
  endtask

  initial begin
    logic [15:0] phase_len;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_write = 1'b0;
    cfg_data = '0;
    idle_on = 1'b1;
    tick_now = '0;
    window_len = frs_pkg::TICKS_RESET;
    n_send = 0;
    n_recv = 0;
    n_clear = 0;
    n_unused = 0;
    n_lengths = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    post_event(frs_pkg::FUNC_SEND, 32'd0, 11'd0, 1'b1);
    post_event(frs_pkg::FUNC_SEND, 32'd999, 11'd1500, 1'b1);
    post_event(frs_pkg::FUNC_SEND, 32'd1000, 11'd2047, 1'b0);
    post_event(frs_pkg::FUNC_RECV, 32'hFFFF_FFFF, 11'h7FF, 1'b1);
    repeat (3) post_event(frs_pkg::FUNC_RECV, 32'd0, 11'd0, 1'b0);
    // more received than sent, loss goes negative
    post_event(frs_pkg::FUNC_SEND, 32'd2000, 11'd1, 1'b1);
    post_event(frs_pkg::FUNC_NONE, 32'hFFFF_FFFF, 11'h7FF, 1'b1);
    post_event(frs_pkg::FUNC_SEND, 32'hFFFF_FFFF, 11'd0, 1'b1);
    // tick count wraps
    post_event(frs_pkg::FUNC_SEND, 32'd998, 11'd700, 1'b1);
    post_event(frs_pkg::FUNC_SEND, 32'd999, 11'd64, 1'b1);
    post_event(frs_pkg::FUNC_CLEAR, 32'hFFFF_FFFF, 11'h7FF, 1'b1);
    post_event(frs_pkg::FUNC_RECV, 32'd5, 11'd1500, 1'b0);
    for (int i = 1; i <= 8; i++)
      post_event(frs_pkg::FUNC_SEND, 32'd999 + 32'(i * 1000), 11'(i * 180), 1'b1);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       phase_len = 16'd0;
        1:       phase_len = 16'd1;
        2:       phase_len = 16'hFFFF;
        3:       phase_len = 16'($urandom_range(2, 300));
        4:       phase_len = 16'($urandom_range(301, 65534));
        default: phase_len = 16'($urandom_range(2, 20));
      endcase
      set_window(phase_len);
      idle_on = (phase != 3);
      if (phase == 2)
        tick_now = 32'hFFF0_0000;
      repeat (172) random_event();
    end

    quiesce();
    repeat (70) @(posedge clk);
    $display("covered %0d sends, %0d receives, %0d clears, %0d unused codes",
             n_send, n_recv, n_clear, n_unused);
    $display("%0d statistics windows closed over %0d window lengths",
             windows_closed, n_lengths + 1);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: files.f
design/frs_pkg.sv
design/frame_rate_statistics.sv
verif/frs_snapshot_check.sv
verif/tb_top.sv
